// ===== hdl/wsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wsp_pkg;

	localparam int COORD_W  = 12;
	localparam int FRAC_W   = 8;
	localparam int CH_W     = 8;
	localparam int N_CH     = 3;
	localparam int PIX_W    = N_CH * CH_W;
	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 32;

	localparam int DEF_MATRIX_WIDTH  = 16;
	localparam int DEF_MATRIX_HEIGHT = 16;

	localparam logic REQ_PLOT = 1'b0;
	localparam logic REQ_READ = 1'b1;

	localparam logic [1:0] CORNER_LAST = 2'd3;

	typedef enum logic {
		ST_CLEAR,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic wr;
		logic last;
		logic is_read;
		logic oor;
		logic fwd_hit;
	} s2_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/wsp_frame_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wsp_frame_ram #(
	parameter int DEPTH  = 256,
	parameter int ADDR_W = 8,
	parameter int DATA_W = 24
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// ===== hdl/wsp_weight_calc.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wsp_weight_calc
	import wsp_pkg::*;
(
	input  wire logic [FRAC_W-1:0] frac_x,
	input  wire logic [FRAC_W-1:0] frac_y,
	input  wire logic [1:0]        corner,
	output logic      [CH_W-1:0]   weight
);

	logic [FRAC_W-1:0]   xx, yy, a, b;
	logic [2*FRAC_W-1:0] prod;
	logic [2*FRAC_W:0]   sum;

	always_comb begin
		// f*255/256 rounded down is f-1 for nonzero f
		xx   = (frac_x == '0) ? '0 : frac_x - FRAC_W'(1);
		yy   = (frac_y == '0) ? '0 : frac_y - FRAC_W'(1);
		a    = corner[0] ? xx : ~xx;
		b    = corner[1] ? yy : ~yy;
		prod = a * b;
		sum  = {1'b0, prod} + (2*FRAC_W+1)'(a) + (2*FRAC_W+1)'(b);
		weight = sum[FRAC_W +: CH_W];
	end

endmodule

`default_nettype wire

// ===== hdl/wsp_pixel_blend.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wsp_pixel_blend
	import wsp_pkg::*;
(
	input  wire s2_ctrl_t            ctrl,
	input  wire logic [PIX_W-1:0]    ram_data,
	input  wire logic [PIX_W-1:0]    fwd_data,
	input  wire logic [CH_W-1:0]     weight,
	input  wire logic [PIX_W-1:0]    colour,
	output logic      [PIX_W-1:0]    wr_data,
	output logic      [M_DATA_W-1:0] res_word
);

	logic [PIX_W-1:0]  base;
	logic [PIX_W-1:0]  shown;
	logic [2*CH_W-1:0] prod;
	logic [CH_W:0]     sum;

	always_comb begin
		base = ctrl.fwd_hit ? fwd_data : ram_data;
		wr_data = '0;
		for (int c = 0; c < N_CH; c++) begin
			prod = colour[c*CH_W +: CH_W] * weight;
			sum  = {1'b0, base[c*CH_W +: CH_W]} + {1'b0, prod[CH_W +: CH_W]};
			wr_data[c*CH_W +: CH_W] = sum[CH_W] ? {CH_W{1'b1}} : sum[CH_W-1:0];
		end
		shown = (ctrl.is_read && !ctrl.oor) ? base : '0;
		// word: red, green, blue from the low byte up, then out of range
		res_word = {{(M_DATA_W-PIX_W-1){1'b0}}, ctrl.is_read & ctrl.oor,
			shown[CH_W-1:0], shown[CH_W +: CH_W], shown[2*CH_W +: CH_W]};
	end

endmodule

`default_nettype wire

// ===== hdl/wu_subpixel_plot_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// order: input registers, s2 with the memory read, result register m_data_q
// throughput: one read-modify-write of a pixel per cycle, four per plot, through
//   the memory write port; a word's last access stalls while the output is full
// reset: arst_n clears control at once; then the frame memory is swept to black,
//   one pixel a cycle, with s_tready low until every pixel is cleared

module wu_subpixel_plot_engine
	import wsp_pkg::*;
#(
	parameter int MATRIX_WIDTH  = DEF_MATRIX_WIDTH,
	parameter int MATRIX_HEIGHT = DEF_MATRIX_HEIGHT
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// x_pos[11:0], y_pos[23:12], red[31:24], green[39:32], blue[47:40]
	input  wire logic [S_DATA_W-1:0] s_tdata,
	// req_type[0]
	input  wire logic                s_tuser,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// read_red[7:0], read_green[15:8], read_blue[23:16], out_of_range[24], zero above
	output logic      [M_DATA_W-1:0] m_tdata
);

	localparam int N_PIX  = MATRIX_WIDTH * MATRIX_HEIGHT;
	localparam int ADDR_W = $clog2(N_PIX);
	localparam int COL_W  = $clog2(MATRIX_WIDTH);
	localparam int ROW_W  = $clog2(MATRIX_HEIGHT);
	localparam int INT_W  = COORD_W - FRAC_W;

	state_t state_q, state_d;
	logic   clearing;
	logic [ADDR_W-1:0] clr_q;

	logic               busy_q;
	logic               req_q;
	logic [COORD_W-1:0] x_q, y_q;
	logic [PIX_W-1:0]   colour_q;
	logic [1:0]         phase_q;

	logic is_final, out_ok, issue, issue_last, accept;
	logic [COORD_W-1:0] plot_col, plot_row, col_sel, row_sel;
	logic               in_bounds;
	logic [ADDR_W-1:0]  rd_addr;
	logic [CH_W-1:0]    weight;

	s2_ctrl_t          ctrl_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic [CH_W-1:0]   weight_s2;
	logic [PIX_W-1:0]  colour_s2;
	logic [PIX_W-1:0]  fwd_data_s2;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_wa;
	logic [PIX_W-1:0]  ram_wd, ram_rd, blend_wd;
	logic [M_DATA_W-1:0] res_word;

	logic                m_valid_q;
	logic [M_DATA_W-1:0] m_data_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == ADDR_W'(N_PIX - 1)) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN:  state_d = ST_RUN;
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		case (state_q)
			ST_CLEAR: clearing = 1'b1;
			ST_RUN:   clearing = 1'b0;
			default:  clearing = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
		end
	end

	always_comb begin
		is_final   = (req_q == REQ_READ) || (phase_q == CORNER_LAST);
		out_ok     = !m_valid_q && !ctrl_s2.last;
		issue      = busy_q && (!is_final || out_ok);
		issue_last = issue && is_final;
		s_tready   = !clearing && (!busy_q || issue_last);
		accept     = s_tvalid && s_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= '0;
		end else begin
			if (accept) begin
				busy_q  <= 1'b1;
				phase_q <= '0;
			end else begin
				if (issue_last) begin
					busy_q <= 1'b0;
				end
				if (issue) begin
					phase_q <= phase_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q    <= s_tuser;
			x_q      <= s_tdata[COORD_W-1:0];
			y_q      <= s_tdata[2*COORD_W-1:COORD_W];
			colour_q <= {s_tdata[31:24], s_tdata[39:32], s_tdata[47:40]};
		end
	end

	always_comb begin
		plot_col = {{FRAC_W{1'b0}}, x_q[COORD_W-1 -: INT_W]}
			+ {{(COORD_W-1){1'b0}}, phase_q[0]};
		plot_row = {{FRAC_W{1'b0}}, y_q[COORD_W-1 -: INT_W]}
			+ {{(COORD_W-1){1'b0}}, phase_q[1]};
		col_sel   = (req_q == REQ_READ) ? x_q : plot_col;
		row_sel   = (req_q == REQ_READ) ? y_q : plot_row;
		in_bounds = (col_sel < COORD_W'(MATRIX_WIDTH)) && (row_sel < COORD_W'(MATRIX_HEIGHT));
		rd_addr   = ADDR_W'(row_sel[ROW_W-1:0]) * ADDR_W'(MATRIX_WIDTH)
			+ ADDR_W'(col_sel[COL_W-1:0]);
	end

	wsp_weight_calc u_weight (
		.frac_x (x_q[FRAC_W-1:0]),
		.frac_y (y_q[FRAC_W-1:0]),
		.corner (phase_q),
		.weight (weight)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else begin
			ctrl_s2.wr      <= issue && (req_q == REQ_PLOT) && in_bounds;
			ctrl_s2.last    <= issue_last;
			ctrl_s2.is_read <= (req_q == REQ_READ);
			ctrl_s2.oor     <= !in_bounds;
			// a write landing in the read cycle is not seen by the memory read
			ctrl_s2.fwd_hit <= ram_we && (ram_wa == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		addr_s2     <= rd_addr;
		weight_s2   <= weight;
		colour_s2   <= colour_q;
		fwd_data_s2 <= ram_wd;
	end

	wsp_pixel_blend u_blend (
		.ctrl     (ctrl_s2),
		.ram_data (ram_rd),
		.fwd_data (fwd_data_s2),
		.weight   (weight_s2),
		.colour   (colour_s2),
		.wr_data  (blend_wd),
		.res_word (res_word)
	);

	always_comb begin
		ram_we = clearing || ctrl_s2.wr;
		ram_wa = clearing ? clr_q : addr_s2;
		ram_wd = clearing ? '0 : blend_wd;
	end

	wsp_frame_ram #(
		.DEPTH  (N_PIX),
		.ADDR_W (ADDR_W),
		.DATA_W (PIX_W)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (ram_wa),
		.wr_data (ram_wd),
		.rd_addr (rd_addr),
		.rd_data (ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else begin
			if (ctrl_s2.last) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_s2.last) begin
			m_data_q <= res_word;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

`default_nettype wire

// ===== hdl/wsp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wsp_assertions
	import wsp_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_tvalid,
	input wire logic                s_tready,
	input wire logic                s_tuser,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [M_DATA_W-1:0] m_tdata
);

	// a plot keeps s_tready low until its last pixel update issues
	a_plot_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == REQ_PLOT) |=> !s_tready ##1 !s_tready ##1 !s_tready)
		else $error("word accepted during plot update");

	a_oor_black: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[PIX_W] |-> (m_tdata[PIX_W-1:0] == '0))
		else $error("out of range result carries colour");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[M_DATA_W-1:PIX_W+1] == '0))
		else $error("result padding not zero");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind wu_subpixel_plot_engine wsp_assertions u_wsp_assertions (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

// ===== dv/wsp_checker.sv =====
`timescale 1ns / 1ps

module wsp_checker
	import wsp_pkg::*;
#(
	parameter int MATRIX_WIDTH  = DEF_MATRIX_WIDTH,
	parameter int MATRIX_HEIGHT = DEF_MATRIX_HEIGHT
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	input  wire logic                s_tready,
	input  wire logic [S_DATA_W-1:0] s_tdata,
	input  wire logic                s_tuser,
	input  wire logic                m_tvalid,
	input  wire logic                m_tready,
	input  wire logic [M_DATA_W-1:0] m_tdata,
	output int                       errors,
	output int                       pending,
	output int                       plots,
	output int                       reads,
	output int                       off_matrix_reads,
	output int                       saturations
);

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            oor;
	} pixel_word_t;

	logic [PIX_W-1:0] frame [MATRIX_WIDTH*MATRIX_HEIGHT];
	pixel_word_t      expected_words [$];

	function automatic logic [CH_W-1:0] corner_weight(input int a, input int b);
		int p;
		p = a * b + a + b;
		return p[15:8];
	endfunction

	function automatic logic [CH_W-1:0] sat_add(input logic [CH_W-1:0] base,
			input logic [CH_W-1:0] colour, input logic [CH_W-1:0] weight);
		int s;
		s = int'(base) + ((int'(colour) * int'(weight)) >> 8);
		if (s > 255) begin
			saturations++;
			return 8'd255;
		end
		return s[7:0];
	endfunction

	function automatic void blend(input int col, input int row, input logic [CH_W-1:0] weight,
			input logic [CH_W-1:0] r, input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
		int idx;
		logic [PIX_W-1:0] pix;
		if (col >= MATRIX_WIDTH || row >= MATRIX_HEIGHT)
			return;
		idx = row * MATRIX_WIDTH + col;
		pix = frame[idx];
		frame[idx] = {sat_add(pix[23:16], r, weight), sat_add(pix[15:8], g, weight),
			sat_add(pix[7:0], b, weight)};
	endfunction

	function automatic pixel_word_t predict_word(input logic req, input logic [S_DATA_W-1:0] d);
		pixel_word_t res;
		logic [COORD_W-1:0] x, y;
		logic [CH_W-1:0] r, g, b;
		logic [PIX_W-1:0] pix;
		int xi, yi, xx, yy, ix, iy;
		res = '0;
		x = d[11:0];
		y = d[23:12];
		r = d[31:24];
		g = d[39:32];
		b = d[47:40];
		if (req == REQ_PLOT) begin
			plots++;
			xi = int'(x) >> FRAC_W;
			yi = int'(y) >> FRAC_W;
			xx = (int'(x[FRAC_W-1:0]) * 255) >> 8;
			yy = (int'(y[FRAC_W-1:0]) * 255) >> 8;
			ix = 255 - xx;
			iy = 255 - yy;
			blend(xi, yi, corner_weight(ix, iy), r, g, b);
			blend(xi + 1, yi, corner_weight(xx, iy), r, g, b);
			blend(xi, yi + 1, corner_weight(ix, yy), r, g, b);
			blend(xi + 1, yi + 1, corner_weight(xx, yy), r, g, b);
		end else begin
			reads++;
			if (x >= MATRIX_WIDTH || y >= MATRIX_HEIGHT) begin
				off_matrix_reads++;
				res.oor = 1'b1;
			end else begin
				pix = frame[int'(y) * MATRIX_WIDTH + int'(x)];
				res.red = pix[23:16];
				res.green = pix[15:8];
				res.blue = pix[7:0];
			end
		end
		return res;
	endfunction

	function automatic void check_field(input string name, input logic [CH_W-1:0] want,
			input logic [CH_W-1:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pixel_word_t want;
		if (!arst_n) begin
			foreach (frame[i])
				frame[i] = '0;
			expected_words.delete();
			errors = 0;
			pending = 0;
			plots = 0;
			reads = 0;
			off_matrix_reads = 0;
			saturations = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_words.size() == 0) begin
					errors++;
					$display("%0t: unexpected result word, expected none, got %h", $time, m_tdata);
				end else begin
					want = expected_words.pop_front();
					check_field("read_red", want.red, m_tdata[7:0]);
					check_field("read_green", want.green, m_tdata[15:8]);
					check_field("read_blue", want.blue, m_tdata[23:16]);
					check_field("out_of_range", {7'd0, want.oor}, {7'd0, m_tdata[24]});
				end
			end
			if (s_tvalid && s_tready)
				expected_words.push_back(predict_word(s_tuser, s_tdata));
			pending = expected_words.size();
		end
	end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import wsp_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_WORDS = 450;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic                s_tuser;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;

	int errors, pending, plots, reads, off_matrix_reads, saturations;
	int cycles = 0;
	int burst_left = 0;
	int rx_mode = 0;
	int rx_len = 0;
	int rx_tick = 0;

	wu_subpixel_plot_engine u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	wsp_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.s_tuser          (s_tuser),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.errors           (errors),
		.pending          (pending),
		.plots            (plots),
		.reads            (reads),
		.off_matrix_reads (off_matrix_reads),
		.saturations      (saturations)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver stall pattern, switching mode every so often
	always @(negedge clk) begin
		if (rx_len == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_len = $urandom_range(20, 200);
		end
		rx_len--;
		rx_tick++;
		case (rx_mode)
			0: m_tready = 1'b1;
			1: m_tready = 1'($urandom_range(0, 1));
			2: m_tready = ($urandom_range(0, 3) == 0);
			default: m_tready = rx_tick[2];
		endcase
	end

	task automatic send_word(input logic req, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, input logic [CH_W-1:0] r,
			input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser = req;
		s_tdata = {b, g, r, y, x};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	initial begin
		logic [COORD_W-1:0] x, y;
		logic [CH_W-1:0] r, g, b;
		logic req;
		bit hot;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = REQ_PLOT;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// directed: fresh frame, saturation, corner spreading, edges of the matrix
		send_word(REQ_READ, 12'd0, 12'd0, 8'hFF, 8'hFF, 8'hFF);
		send_word(REQ_PLOT, 12'h000, 12'h000, 8'd255, 8'd255, 8'd255);
		send_word(REQ_READ, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0);
		send_word(REQ_PLOT, 12'h000, 12'h000, 8'd255, 8'd0, 8'd128);
		send_word(REQ_READ, 12'd0, 12'd0, 8'd0, 8'd0, 8'd0);
		send_word(REQ_PLOT, 12'h380, 12'h2FF, 8'd200, 8'd100, 8'd50);
		send_word(REQ_READ, 12'd3, 12'd2, 8'd0, 8'd0, 8'd0);
		send_word(REQ_READ, 12'd4, 12'd2, 8'd0, 8'd0, 8'd0);
		send_word(REQ_READ, 12'd3, 12'd3, 8'd0, 8'd0, 8'd0);
		send_word(REQ_READ, 12'd4, 12'd3, 8'd0, 8'd0, 8'd0);
		send_word(REQ_PLOT, 12'hF40, 12'hFC0, 8'd255, 8'd255, 8'd255);
		send_word(REQ_READ, 12'd15, 12'd15, 8'd0, 8'd0, 8'd0);
		send_word(REQ_PLOT, 12'hFFF, 12'hFFF, 8'd255, 8'd255, 8'd255);
		send_word(REQ_PLOT, 12'h5A7, 12'h53C, 8'd0, 8'd0, 8'd0);
		send_word(REQ_READ, 12'd5, 12'd5, 8'd0, 8'd0, 8'd0);
		send_word(REQ_PLOT, 12'h0FF, 12'hEFF, 8'd1, 8'd128, 8'd254);
		send_word(REQ_READ, 12'd1, 12'd15, 8'd0, 8'd0, 8'd0);
		send_word(REQ_READ, 12'd16, 12'd0, 8'd0, 8'd0, 8'd0);
		send_word(REQ_READ, 12'd0, 12'd16, 8'd0, 8'd0, 8'd0);
		send_word(REQ_READ, 12'hFFF, 12'hFFF, 8'd0, 8'd0, 8'd0);
		send_word(REQ_READ, 12'd15, 12'd0, 8'hAA, 8'h55, 8'hFF);
		send_word(REQ_READ, 12'd0, 12'd15, 8'd0, 8'd0, 8'd0);
		drain();

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == RANDOM_WORDS / 2)
				drain();
			// a crowded stretch in one corner drives channels into saturation
			hot = (i >= 300 && i < 380);
			req = ($urandom_range(0, 9) < 6) ? REQ_PLOT : REQ_READ;
			r = CH_W'($urandom);
			g = CH_W'($urandom);
			b = CH_W'($urandom);
			if (req == REQ_PLOT) begin
				if (hot) begin
					x = COORD_W'($urandom_range(0, 767));
					y = COORD_W'($urandom_range(0, 767));
					r = CH_W'($urandom_range(160, 255));
					g = CH_W'($urandom_range(160, 255));
					b = CH_W'($urandom_range(160, 255));
				end else begin
					x = COORD_W'($urandom);
					y = COORD_W'($urandom);
				end
			end else if ($urandom_range(0, 4) == 0) begin
				x = COORD_W'($urandom);
				y = COORD_W'($urandom);
			end else begin
				x = hot ? COORD_W'($urandom_range(0, 3)) : COORD_W'($urandom_range(0, 15));
				y = hot ? COORD_W'($urandom_range(0, 3)) : COORD_W'($urandom_range(0, 15));
			end
			send_word(req, x, y, r, g, b);
		end

		drain();
		repeat (10) @(negedge clk);
		$display("run covered %0d plots and %0d pixel reads (%0d off the matrix)",
			plots, reads, off_matrix_reads);
		$display("channel updates clipped at full scale: %0d", saturations);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== wu_subpixel_plot_engine.f =====
hdl/wsp_pkg.sv
hdl/wsp_frame_ram.sv
hdl/wsp_weight_calc.sv
hdl/wsp_pixel_blend.sv
hdl/wu_subpixel_plot_engine.sv
hdl/wsp_checker.sv
dv/wsp_checker.sv
dv/testbench.sv
